[sv/refcounted_ring_slot_tracker_unit_macros.svh]
// Assertion helpers shared by the tracker RTL.
`ifndef REFCOUNTED_RING_SLOT_TRACKER_UNIT_MACROS_SVH
`define REFCOUNTED_RING_SLOT_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RRST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tracker check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RRST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tracker check failed");

`endif

[sv/rrst_pkg.sv]
package rrst_pkg;

	localparam int RRST_RING_SLOTS = 8;
	localparam int OFF_W = 16;
	localparam int CNT_W = 8;
	localparam int REQ_W = 2;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_FILL  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_USE   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

	// Cell row operations
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_DEC   = 2'd2;
	localparam logic [1:0] CMD_SHIFT = 2'd3;

	typedef struct packed {
		logic [1:0]       op;
		logic [CNT_W-1:0] wval;
	} row_cmd_t;

	typedef struct packed {
		logic             wr;
		logic             dec;
		logic             shift;
		logic [CNT_W-1:0] wval;
	} cell_ctrl_t;

endpackage

[sv/refcounted_ring_slot_tracker_unit.sv]
// Reference-counted ring slot tracker.
// Input channel (in_valid / in_stall) carries one request: req_type and
// batch_offset. Fill takes the tail offset, use drops one count of an offset
// inside the head..tail window, query changes nothing. Output channel
// (out_valid / out_stall) returns one result per request with the window
// status, an error flag and the head and tail offsets after the request.
// cfg_we / cfg_wdata write consumer_count; write it only while idle.
// Slot counts live in a row of cells ordered by distance from the head;
// releasing the head shifts the whole row down by one cell per cycle.
// Steps: decide, then release up to RING_SLOTS slots at the head (skipped
// for a refused request), then post the result. The input takes the next
// request once the result posts. One request is in flight at a time; the
// next may be taken while the previous result still waits on out_stall.
// A stalled result holds; a finished request waits for the output register.
// Reset clears head, tail and occupancy and sets consumer_count to 1; slot
// counts need no clearing.
module refcounted_ring_slot_tracker_unit
	import rrst_pkg::*;
#(
	parameter int RING_SLOTS = RRST_RING_SLOTS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [REQ_W-1:0] req_type,
	input  logic [OFF_W-1:0] batch_offset,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             has_free_slot,
	output logic             offset_ready,
	output logic             offset_is_tail,
	output logic             request_error,
	output logic [OFF_W-1:0] head_offset,
	output logic [OFF_W-1:0] tail_offset
);

`include "refcounted_ring_slot_tracker_unit_macros.svh"

	localparam int IDX_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam int OCC_W = $clog2(RING_SLOTS + 1);
	localparam logic [OCC_W-1:0] SLOTS_OCC = OCC_W'(RING_SLOTS);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_DECIDE  = 2'd1;
	localparam logic [1:0] ST_ADVANCE = 2'd2;
	localparam logic [1:0] ST_DONE    = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] consumer_count_q;
	logic [OFF_W-1:0] head_q;
	logic [OFF_W-1:0] tail_q;
	logic [OCC_W-1:0] occ_q;
	logic [REQ_W-1:0] req_q;
	logic [OFF_W-1:0] off_q;
	logic             err_q;
	logic             out_valid_q;
	logic             free_q;
	logic             ready_q;
	logic             is_tail_q;
	logic             out_err_q;
	logic [OFF_W-1:0] out_head_q;
	logic [OFF_W-1:0] out_tail_q;

	row_cmd_t         row_cmd;
	logic [IDX_W-1:0] row_idx;
	logic [CNT_W-1:0] sel_count;
	logic [CNT_W-1:0] head_count;
	logic [OFF_W-1:0] rel;
	logic             in_window;
	logic             decide_err;
	logic             adv_step;
	logic             in_take;
	logic             out_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign rel       = off_q - head_q;
	assign in_window = rel < OFF_W'(occ_q);
	assign adv_step  = (occ_q != '0) && (head_count == '0);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// Check the request and pick the cell operation
	always_comb begin
		row_cmd.op   = CMD_NONE;
		row_cmd.wval = consumer_count_q;
		row_idx      = '0;
		decide_err   = 1'b0;
		case (req_q)
			REQ_FILL: begin
				decide_err = (off_q != tail_q) || (occ_q >= SLOTS_OCC);
				row_idx    = occ_q[IDX_W-1:0];
			end
			REQ_USE: begin
				row_idx    = rel[IDX_W-1:0];
				decide_err = !in_window || (sel_count == '0);
			end
			REQ_QUERY: decide_err = 1'b0;
			default:   decide_err = 1'b1;
		endcase
		if (state_q == ST_DECIDE && !decide_err) begin
			if (req_q == REQ_FILL) begin
				row_cmd.op = CMD_WRITE;
			end else if (req_q == REQ_USE) begin
				row_cmd.op = CMD_DEC;
			end
		end else if (state_q == ST_ADVANCE && adv_step) begin
			row_cmd.op = CMD_SHIFT;
		end
	end

	rrst_cell_row #(
		.RING_SLOTS (RING_SLOTS),
		.IDX_W      (IDX_W)
	) u_row (
		.clk        (clk),
		.cmd        (row_cmd),
		.idx        (row_idx),
		.sel_count  (sel_count),
		.head_count (head_count)
	);

	// Sequence one request: decide, release head slots, post result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			consumer_count_q <= CNT_W'(1);
			head_q           <= '0;
			tail_q           <= '0;
			occ_q            <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				consumer_count_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!decide_err && req_q == REQ_FILL) begin
						tail_q <= tail_q + OFF_W'(1);
						occ_q  <= occ_q + OCC_W'(1);
					end
					state_q <= decide_err ? ST_DONE : ST_ADVANCE;
				end
				ST_ADVANCE: begin
					if (adv_step) begin
						head_q <= head_q + OFF_W'(1);
						occ_q  <= occ_q - OCC_W'(1);
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the request fields and the decision
	always_ff @(posedge clk) begin
		if (in_take) begin
			req_q <= req_type;
			off_q <= batch_offset;
		end
		if (state_q == ST_DECIDE) begin
			err_q <= decide_err;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			free_q     <= occ_q < SLOTS_OCC;
			ready_q    <= in_window;
			is_tail_q  <= off_q == tail_q;
			out_err_q  <= err_q;
			out_head_q <= head_q;
			out_tail_q <= tail_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign has_free_slot  = free_q;
	assign offset_ready   = ready_q;
	assign offset_is_tail = is_tail_q;
	assign request_error  = out_err_q;
	assign head_offset    = out_head_q;
	assign tail_offset    = out_tail_q;

	`RRST_ASSERT_NOW(a_occ_bound, clk, arst_n, 1'b1, occ_q <= SLOTS_OCC)
	`RRST_ASSERT_NOW(a_window_span, clk, arst_n, 1'b1, (tail_q - head_q) == OFF_W'(occ_q))
	`RRST_ASSERT_NEXT(a_take_decides, clk, arst_n, in_take, state_q == ST_DECIDE)
	`RRST_ASSERT_NEXT(a_head_step, clk, arst_n, state_q == ST_ADVANCE && adv_step, head_q == $past(head_q) + OFF_W'(1))

endmodule

[sv/rrst_cell.sv]
module rrst_cell
	import rrst_pkg::*;
(
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [CNT_W-1:0] shift_in,
	output logic [CNT_W-1:0] count
);

	logic [CNT_W-1:0] count_q;

	// Take the neighbor's count on a shift, else load or decrement in place
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			count_q <= shift_in;
		end else if (ctrl.wr) begin
			count_q <= ctrl.wval;
		end else if (ctrl.dec) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign count = count_q;

endmodule

[sv/rrst_cell_row.sv]
module rrst_cell_row
	import rrst_pkg::*;
#(
	parameter int RING_SLOTS = RRST_RING_SLOTS,
	parameter int IDX_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1
) (
	input  logic             clk,
	input  row_cmd_t         cmd,
	input  logic [IDX_W-1:0] idx,
	output logic [CNT_W-1:0] sel_count,
	output logic [CNT_W-1:0] head_count
);

	logic [CNT_W-1:0] counts [RING_SLOTS];

	// Cell i holds the count of the slot i places past the head
	for (genvar i = 0; i < RING_SLOTS; i++) begin : g_cell
		cell_ctrl_t       ctrl;
		logic [CNT_W-1:0] shift_in;

		assign ctrl.wr    = (cmd.op == CMD_WRITE) && (idx == IDX_W'(i));
		assign ctrl.dec   = (cmd.op == CMD_DEC) && (idx == IDX_W'(i));
		assign ctrl.shift = (cmd.op == CMD_SHIFT);
		assign ctrl.wval  = cmd.wval;

		// Last cell keeps its own value; it is never read before a fill
		if (i == RING_SLOTS - 1) begin : g_last
			assign shift_in = counts[i];
		end else begin : g_mid
			assign shift_in = counts[i+1];
		end

		rrst_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.shift_in (shift_in),
			.count    (counts[i])
		);
	end

	assign sel_count  = counts[idx];
	assign head_count = counts[0];

endmodule
